[sv/longest_common_substring_length_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the longest common substring length unit
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LONGEST_COMMON_SUBSTRING_LENGTH_UNIT_ASSERT_SVH
`define LONGEST_COMMON_SUBSTRING_LENGTH_UNIT_ASSERT_SVH

// Same-cycle implication
`define LCSL_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define LCSL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/lcsl_pkg.sv]
// ----------------------------------------------------------------------------
// lcsl_pkg
// Shared constants, types and codes of the longest common substring unit.
// ----------------------------------------------------------------------------
package lcsl_pkg;

	// Pattern store size, one cell per pattern byte
	localparam int MAX_PATTERN = 256;

	localparam int SYM_W   = 8;
	localparam int RUN_W   = 9;
	localparam int CNT_W   = $clog2(MAX_PATTERN + 1);
	localparam int DRAIN_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int OUT_W   = 16;

	localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

	// Item kinds carried on tuser
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TEXT = 1'b1;

	typedef enum logic [0:0] {
		ST_RUN,
		ST_DRAIN
	} state_t;

	// Broadcast control from the controller to every cell
	typedef struct packed {
		logic             load_en;
		logic [CNT_W-1:0] wr_idx;
		logic             text_en;
		logic [SYM_W-1:0] symbol;
		logic [CNT_W-1:0] fill;
		logic             clr_row;
	} cell_ctl_t;

endpackage

[sv/longest_common_substring_length_unit.sv]
// ----------------------------------------------------------------------------
// longest_common_substring_length_unit
// Longest common substring length of a stored pattern and a streamed text,
// computed by a chain of cells, one per pattern byte.
// ----------------------------------------------------------------------------
//
// Channel  Dir  tdata                          tuser         tlast
// s_*      in   [7:0] symbol                   [0] mode      last byte
// m_*      out  [8:0] best_length, [9] overflow  -            -
//
// Flow: pattern and text bytes are taken while s_tready is high. The final
// text byte starts a drain with s_tready low while the best length
// ripples down the cell chain, one cell per cycle, into the result register.
// Reset: asynchronous; the pattern is empty and the next load starts a new one.
// Stalls: a held result blocks only the end of the next drain; loads and text
// bytes keep flowing while it waits.
//
module longest_common_substring_length_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] symbol
	input  logic [0:0]                    s_tuser,   // [0] mode
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata    // [8:0] best_length, [9] pattern_overflow
);

	lcsl_pkg::cell_ctl_t         ctl;
	logic [lcsl_pkg::RUN_W-1:0]  run_w  [lcsl_pkg::MAX_PATTERN];
	logic [lcsl_pkg::RUN_W-1:0]  best_w [lcsl_pkg::MAX_PATTERN];

	// Controller
	lcsl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.chain_best (best_w[lcsl_pkg::MAX_PATTERN-1]),
		.ctl        (ctl)
	);

	// Cell chain; cell 0 sees an empty left neighbor
	for (genvar k = 0; k < lcsl_pkg::MAX_PATTERN; k++) begin : g_cell
		logic [lcsl_pkg::RUN_W-1:0] left_run;
		logic [lcsl_pkg::RUN_W-1:0] left_best;

		if (k == 0) begin : g_head
			assign left_run  = '0;
			assign left_best = '0;
		end else begin : g_body
			assign left_run  = run_w[k-1];
			assign left_best = best_w[k-1];
		end

		lcsl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.idx       (lcsl_pkg::CNT_W'(k)),
			.left_run  (left_run),
			.left_best (left_best),
			.run       (run_w[k]),
			.best      (best_w[k])
		);
	end

endmodule

[sv/lcsl_cell.sv]
// ----------------------------------------------------------------------------
// lcsl_cell
// One pattern position: holds its pattern byte, the match run ending here and
// the best run seen so far; takes run and best from its left neighbor.
// ----------------------------------------------------------------------------
module lcsl_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lcsl_pkg::cell_ctl_t           ctl,
	input  logic [lcsl_pkg::CNT_W-1:0]    idx,
	input  logic [lcsl_pkg::RUN_W-1:0]    left_run,
	input  logic [lcsl_pkg::RUN_W-1:0]    left_best,
	output logic [lcsl_pkg::RUN_W-1:0]    run,
	output logic [lcsl_pkg::RUN_W-1:0]    best
);

	logic [lcsl_pkg::SYM_W-1:0] pat_q;
	logic [lcsl_pkg::RUN_W-1:0] run_q;
	logic [lcsl_pkg::RUN_W-1:0] best_q;
	logic                       valid;
	logic                       hit;
	logic [lcsl_pkg::RUN_W-1:0] run_nxt;
	logic [lcsl_pkg::RUN_W-1:0] run_cand;
	logic [lcsl_pkg::RUN_W-1:0] best_nxt;

	// Position holds a pattern byte once the fill count passes it
	assign valid = (idx < ctl.fill);
	assign hit   = ctl.load_en && (idx == ctl.wr_idx);

	// Extend the left neighbor's run on a match, saturating
	always_comb begin
		if (valid && (pat_q == ctl.symbol)) begin
			if (left_run == lcsl_pkg::RUN_MAX) begin
				run_nxt = lcsl_pkg::RUN_MAX;
			end else begin
				run_nxt = left_run + lcsl_pkg::RUN_W'(1);
			end
		end else begin
			run_nxt = '0;
		end
	end

	// Keep the running maximum moving down the chain
	always_comb begin
		run_cand = ctl.text_en ? run_nxt : '0;
		best_nxt = best_q;
		if (left_best > best_nxt) begin
			best_nxt = left_best;
		end
		if (run_cand > best_nxt) begin
			best_nxt = run_cand;
		end
	end

	// Pattern byte
	always_ff @(posedge clk) begin
		if (hit) begin
			pat_q <= ctl.symbol;
		end
	end

	// Run and best
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= '0;
			best_q <= '0;
		end else if (ctl.clr_row) begin
			run_q  <= '0;
			best_q <= '0;
		end else begin
			if (ctl.text_en) begin
				run_q <= run_nxt;
			end
			best_q <= best_nxt;
		end
	end

	assign run  = run_q;
	assign best = best_q;

endmodule

[sv/lcsl_ctrl.sv]
// ----------------------------------------------------------------------------
// lcsl_ctrl
// Input and output handshakes, pattern fill count, overflow flag, the drain
// sequence after a final text byte and the result register.
// ----------------------------------------------------------------------------
module lcsl_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [lcsl_pkg::SYM_W-1:0]    s_tdata,
	input  logic [0:0]                    s_tuser,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lcsl_pkg::OUT_W-1:0]    m_tdata,
	input  logic [lcsl_pkg::RUN_W-1:0]    chain_best,
	output lcsl_pkg::cell_ctl_t           ctl
);

	localparam logic [lcsl_pkg::DRAIN_W-1:0] DRAIN_LAST =
		lcsl_pkg::DRAIN_W'(lcsl_pkg::MAX_PATTERN - 1);
	localparam logic [lcsl_pkg::CNT_W-1:0] CNT_FULL =
		lcsl_pkg::CNT_W'(lcsl_pkg::MAX_PATTERN);
	localparam int PAD_W = lcsl_pkg::OUT_W - lcsl_pkg::RUN_W - 1;

	lcsl_pkg::state_t              state_q, state_nxt;
	logic [lcsl_pkg::DRAIN_W-1:0]  drain_cnt_q;
	logic [lcsl_pkg::CNT_W-1:0]    count_q;
	logic                          closed_q;
	logic                          overflow_q;
	logic                          out_valid_q;
	logic [lcsl_pkg::RUN_W-1:0]    out_best_q;
	logic                          out_ovf_q;

	logic                          accept;
	logic                          is_text;
	logic                          load_en;
	logic                          text_en;
	logic                          new_pat;
	logic [lcsl_pkg::CNT_W-1:0]    base_cnt;
	logic                          full;
	logic                          drain_done;

	// Decode the incoming transaction
	assign accept   = s_tvalid && s_tready;
	assign is_text  = (s_tuser[0] == lcsl_pkg::MODE_TEXT);
	assign load_en  = accept && !is_text;
	assign text_en  = accept && is_text;
	assign new_pat  = load_en && closed_q;
	assign base_cnt = closed_q ? '0 : count_q;
	assign full     = (base_cnt == CNT_FULL);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lcsl_pkg::ST_RUN: begin
				if (text_en && s_tlast) begin
					state_nxt = lcsl_pkg::ST_DRAIN;
				end
			end
			lcsl_pkg::ST_DRAIN: begin
				if (drain_done) begin
					state_nxt = lcsl_pkg::ST_RUN;
				end
			end
			default: state_nxt = lcsl_pkg::ST_RUN;
		endcase
	end

	// State outputs and cell control
	always_comb begin
		s_tready    = (state_q == lcsl_pkg::ST_RUN);
		drain_done  = (state_q == lcsl_pkg::ST_DRAIN) && (drain_cnt_q == DRAIN_LAST)
			&& (!out_valid_q || m_tready);
		ctl.load_en = load_en;
		ctl.wr_idx  = base_cnt;
		ctl.text_en = text_en;
		ctl.symbol  = s_tdata;
		ctl.fill    = count_q;
		ctl.clr_row = new_pat || drain_done;
	end

	// State and drain counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcsl_pkg::ST_RUN;
			drain_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q != lcsl_pkg::ST_DRAIN) begin
				drain_cnt_q <= '0;
			end else if (drain_cnt_q != DRAIN_LAST) begin
				drain_cnt_q <= drain_cnt_q + lcsl_pkg::DRAIN_W'(1);
			end
		end
	end

	// Pattern fill count, open/closed mark and overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			closed_q   <= 1'b1;
			overflow_q <= 1'b0;
		end else if (load_en) begin
			count_q    <= full ? base_cnt : base_cnt + lcsl_pkg::CNT_W'(1);
			overflow_q <= (closed_q ? 1'b0 : overflow_q) | full;
			closed_q   <= s_tlast;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (drain_done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drain_done) begin
			out_best_q <= chain_best;
			out_ovf_q  <= overflow_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_ovf_q, out_best_q};

endmodule

[sv/lcsl_checker.sv]
// ----------------------------------------------------------------------------
// lcsl_checker
// Port-level checks of the longest common substring length unit.
// ----------------------------------------------------------------------------
`include "longest_common_substring_length_unit_assert.svh"

module lcsl_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata
);

	logic s_xact;

	assign s_xact = s_tvalid && s_tready;

	// Result transaction holds while stalled
	`LCSL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	// Final text byte starts a drain that blocks input
	`LCSL_ASSERT_NEXT(a_drain_blocks, s_xact && (s_tuser[0] == lcsl_pkg::MODE_TEXT) && s_tlast, !s_tready, "input open right after final text byte")
	// A pattern load never produces a result
	`LCSL_ASSERT_NEXT(a_load_silent, s_xact && (s_tuser[0] == lcsl_pkg::MODE_LOAD) && !m_tvalid, !m_tvalid, "result after a pattern load")
	// A result appears only at the end of a drain
	`LCSL_ASSERT_IMPL(a_result_after_drain, $rose(m_tvalid), $past(!s_tready), "result without a drain")

endmodule

bind longest_common_substring_length_unit lcsl_checker u_lcsl_checker (.*);
